[src/dpc_pkg.sv]
package dpc_pkg;

  localparam int COORD_BITS      = 11;
  localparam int BYTES_PER_PIXEL = 3;

  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 24;
  localparam int SCALE_W = 24;
  localparam int COEF_W  = 32;
  localparam int BOUND_W = 32;
  localparam int FILL_W  = 8;
  localparam int CFG_W   = 32;

  // scaled depth product and its q16.16 meters slice
  localparam int ZP_W    = SCALE_W + DEPTH_W;
  localparam int Z_FRAC  = 8;
  localparam int Z_W     = ZP_W - Z_FRAC;
  // coordinate terms, q.24
  localparam int PXY_W   = COEF_W + COORD_BITS + 1;
  localparam int SUM_W   = PXY_W + 1;
  // depth term before and after dropping 16 fraction bits
  localparam int TZP_W   = COEF_W + Z_W + 1;
  localparam int TZ_SH   = 16;
  localparam int TZ_W    = TZP_W - TZ_SH;
  // projected distance, q.24
  localparam int D_W     = ((TZ_W > SUM_W) ? TZ_W : SUM_W) + 1;
  localparam int D_FRAC  = 24;
  localparam int BND_SH  = 8;

  localparam int FILL_BYTES = (BYTES_PER_PIXEL > 3) ? 3 : BYTES_PER_PIXEL;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_COEF_X      = 3'd1,
    REG_COEF_Y      = 3'd2,
    REG_COEF_Z      = 3'd3,
    REG_Z_LOW       = 3'd4,
    REG_Z_HIGH      = 3'd5,
    REG_FILL_BYTE   = 3'd6
  } reg_idx_e;

  localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = 24'd16777;
  localparam logic [COEF_W-1:0]  RST_COEF_X      = 32'h0000_0000;
  localparam logic [COEF_W-1:0]  RST_COEF_Y      = 32'h0000_0000;
  localparam logic [COEF_W-1:0]  RST_COEF_Z      = 32'h0100_0000;
  localparam logic [BOUND_W-1:0] RST_Z_LOW       = 32'h0000_0000;
  localparam logic [BOUND_W-1:0] RST_Z_HIGH      = 32'h7fff_ffff;
  localparam logic [FILL_W-1:0]  RST_FILL_BYTE   = 8'hff;

  typedef struct packed {
    logic [SCALE_W-1:0] depth_scale;
    logic [COEF_W-1:0]  coef_x;
    logic [COEF_W-1:0]  coef_y;
    logic [COEF_W-1:0]  coef_z;
    logic [BOUND_W-1:0] z_low_bound;
    logic [BOUND_W-1:0] z_high_bound;
    logic [FILL_W-1:0]  fill_byte;
  } cfg_t;

  typedef struct packed {
    logic signed [D_W-1:0] pdist;
    logic [DEPTH_W-1:0]    depth_raw;
    logic [COLOR_W-1:0]    color;
  } proj_t;

endpackage

[src/dpc_if.sv]
interface pix_in_if import dpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [DEPTH_W-1:0]    depth_raw;
  logic [COLOR_W-1:0]    color_in;

  modport source (output valid, pixel_x, pixel_y, depth_raw, color_in, input ready);
  modport sink   (input valid, pixel_x, pixel_y, depth_raw, color_in, output ready);
endinterface

interface pix_out_if import dpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               culled;
  logic [DEPTH_W-1:0] depth_out;
  logic [COLOR_W-1:0] color_out;

  modport source (output valid, culled, depth_out, color_out, input ready);
  modport sink   (input valid, culled, depth_out, color_out, output ready);
endinterface

[src/dpc_cfg.sv]
module dpc_cfg import dpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DEPTH_SCALE: cfg_d.depth_scale  = cfg_data_i[SCALE_W-1:0];
        REG_COEF_X:      cfg_d.coef_x       = cfg_data_i[COEF_W-1:0];
        REG_COEF_Y:      cfg_d.coef_y       = cfg_data_i[COEF_W-1:0];
        REG_COEF_Z:      cfg_d.coef_z       = cfg_data_i[COEF_W-1:0];
        REG_Z_LOW:       cfg_d.z_low_bound  = cfg_data_i[BOUND_W-1:0];
        REG_Z_HIGH:      cfg_d.z_high_bound = cfg_data_i[BOUND_W-1:0];
        REG_FILL_BYTE:   cfg_d.fill_byte    = cfg_data_i[FILL_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_scale  <= RST_DEPTH_SCALE;
      cfg_q.coef_x       <= RST_COEF_X;
      cfg_q.coef_y       <= RST_COEF_Y;
      cfg_q.coef_z       <= RST_COEF_Z;
      cfg_q.z_low_bound  <= RST_Z_LOW;
      cfg_q.z_high_bound <= RST_Z_HIGH;
      cfg_q.fill_byte    <= RST_FILL_BYTE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/dpc_proj.sv]
module dpc_proj import dpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  pix_in_if.sink   pix_i,
  output logic     valid_o,
  input  logic     ready_i,
  output proj_t    proj_o
);

  // stage 1: depth scale and coordinate products
  logic                     v1_q;
  logic [ZP_W-1:0]          zp1_q;
  logic signed [PXY_W-1:0]  px1_q, py1_q;
  logic [DEPTH_W-1:0]       raw1_q;
  logic [COLOR_W-1:0]       col1_q;
  // stage 2: depth term product and coordinate sum
  logic                     v2_q;
  logic signed [TZP_W-1:0]  tzp2_q;
  logic signed [SUM_W-1:0]  pxy2_q;
  logic [DEPTH_W-1:0]       raw2_q;
  logic [COLOR_W-1:0]       col2_q;
  // stage 3: projected distance
  logic                     v3_q;
  logic signed [D_W-1:0]    d3_q;
  logic [DEPTH_W-1:0]       raw3_q;
  logic [COLOR_W-1:0]       col3_q;

  logic                     rdy1, rdy2, rdy3;
  logic [Z_W-1:0]           z2;
  logic signed [TZ_W-1:0]   tz3;
  logic signed [D_W-1:0]    d3_d;

  assign rdy3 = !v3_q || ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign pix_i.ready = rdy1;

  assign z2   = zp1_q[ZP_W-1:Z_FRAC];
  assign tz3  = tzp2_q[TZP_W-1:TZ_SH];
  assign d3_d = D_W'(tz3) + D_W'(pxy2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_i.valid) begin
      zp1_q  <= ZP_W'(cfg_i.depth_scale) * ZP_W'(pix_i.depth_raw);
      px1_q  <= PXY_W'($signed(cfg_i.coef_x)) * PXY_W'($signed({1'b0, pix_i.pixel_x}));
      py1_q  <= PXY_W'($signed(cfg_i.coef_y)) * PXY_W'($signed({1'b0, pix_i.pixel_y}));
      raw1_q <= pix_i.depth_raw;
      col1_q <= pix_i.color_in;
    end
    if (rdy2 && v1_q) begin
      tzp2_q <= TZP_W'($signed(cfg_i.coef_z)) * TZP_W'($signed({1'b0, z2}));
      pxy2_q <= SUM_W'(px1_q) + SUM_W'(py1_q);
      raw2_q <= raw1_q;
      col2_q <= col1_q;
    end
    if (rdy3 && v2_q) begin
      d3_q   <= d3_d;
      raw3_q <= raw2_q;
      col3_q <= col2_q;
    end
  end

  assign valid_o          = v3_q;
  assign proj_o.pdist     = d3_q;
  assign proj_o.depth_raw = raw3_q;
  assign proj_o.color     = col3_q;

endmodule

[src/dpc_cull.sv]
module dpc_cull import dpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  proj_t     proj_i,
  pix_out_if.source res_o
);

  logic                  vo_q;
  logic                  cull_q;
  logic [DEPTH_W-1:0]    dep_q;
  logic [COLOR_W-1:0]    col_q;

  logic signed [D_W-1:0] lo, hi;
  logic                  cull_d;
  logic [DEPTH_W-1:0]    dep_sat;
  logic [COLOR_W-1:0]    col_fill;

  assign lo = D_W'($signed({cfg_i.z_low_bound, BND_SH'(0)}));
  assign hi = D_W'($signed({cfg_i.z_high_bound, BND_SH'(0)}));
  assign cull_d = (proj_i.pdist <= lo) || (proj_i.pdist >= hi);

  always_comb begin
    if (proj_i.pdist[D_W-1]) begin
      dep_sat = '0;
    end else if (|proj_i.pdist[D_W-2:D_FRAC+DEPTH_W]) begin
      dep_sat = '1;
    end else begin
      dep_sat = proj_i.pdist[D_FRAC+DEPTH_W-1:D_FRAC];
    end
  end

  always_comb begin
    col_fill = proj_i.color;
    for (int i = 0; i < FILL_BYTES; i++) begin
      col_fill[8*i +: 8] = cfg_i.fill_byte;
    end
  end

  assign ready_o = !vo_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (ready_o) begin
      vo_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cull_q <= cull_d;
      dep_q  <= cull_d ? dep_sat : proj_i.depth_raw;
      col_q  <= cull_d ? col_fill : proj_i.color;
    end
  end

  assign res_o.valid     = vo_q;
  assign res_o.culled    = cull_q;
  assign res_o.depth_out = dep_q;
  assign res_o.color_out = col_q;

endmodule

[src/depth_plane_cull.sv]
// throughput: one pixel per cycle while res_o takes results; res_o back-pressure stalls it
// four-stage pipeline with per-stage valid bits
// stage 1 scale and coordinate multiplies, stage 2 depth-term multiply,
// stage 3 distance add, stage 4 band compare into the output register
// reset: asynchronous, clears all valid bits and loads register defaults
module depth_plane_cull import dpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  pix_in_if.sink               pix_i,
  pix_out_if.source            res_o
);

  cfg_t  cfg;
  logic  proj_valid;
  logic  proj_ready;
  proj_t proj;

  dpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dpc_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pix_i   (pix_i),
    .valid_o (proj_valid),
    .ready_i (proj_ready),
    .proj_o  (proj)
  );

  dpc_cull u_cull (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (proj_valid),
    .ready_o (proj_ready),
    .proj_i  (proj),
    .res_o   (res_o)
  );

endmodule

[src/dpc_checker.sv]
module dpc_checker import dpc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               culled_i,
  input logic [DEPTH_W-1:0] depth_out_i,
  input logic [COLOR_W-1:0] color_out_i
);

  localparam int MAX_INFLIGHT = 4;

  logic [2:0] inflight_q, inflight_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_xfer && !out_xfer) begin
      inflight_d = inflight_q + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // no result shows while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(culled_i)
      && $stable(depth_out_i) && $stable(color_out_i))
    else $error("stalled result changed");

  // pipeline never holds more pixels than it has stages
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'(MAX_INFLIGHT))
    else $error("too many pixels in flight");

  // every result has an accepted pixel behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 3'd0)
    else $error("result without input");

endmodule

bind depth_plane_cull dpc_checker u_dpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .culled_i    (res_o.culled),
  .depth_out_i (res_o.depth_out),
  .color_out_i (res_o.color_out)
);
